### design/trc_pkg.sv
// Shared types and constants for the touch report to cursor block.
// No dependencies; every other design file imports this package.
package trc_pkg;

  // Defaults for the top level parameters.
  localparam int unsigned MAX_REPORT_BYTES_DEF = 64;
  localparam int unsigned COORD_BITS_DEF       = 12;

  // Fixed field widths.
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned DECL_W      = 16;
  localparam int unsigned SCREEN_W    = 13;
  localparam int unsigned MAXIN_W     = 8;
  localparam int unsigned OUT_COORD_W = 12;
  localparam int unsigned TOUCH_W     = 12;
  localparam int unsigned FIELD_BYTES = 6;

  // Touch panel full scale.
  localparam int unsigned TOUCH_MAX_X = 3675;
  localparam int unsigned TOUCH_MAX_Y = 2261;

  // Report ids and bits.
  localparam logic [BYTE_W-1:0] ID_TOUCH  = 8'h04;
  localparam logic [BYTE_W-1:0] ID_MOUSE  = 8'h01;
  localparam int unsigned       TIP_BIT   = 1;
  localparam int unsigned       LEFT_BIT  = 0;
  localparam int unsigned       RIGHT_BIT = 1;

  // Length rules.
  localparam int unsigned MIN_DECL_LEN   = 3;
  localparam int unsigned FULL_TOUCH_LEN = 8;
  localparam int unsigned MIN_INPUT_LEN  = 4;
  localparam int unsigned ACCEL_KNEE     = 3;

  // Register map, index is paddr[3:2].
  localparam int unsigned APB_AW = 4;
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_INPUT_LEN = 2'd2;

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd768;
  localparam logic [MAXIN_W-1:0]  MAX_INPUT_RST     = 8'd64;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TOUCH = 2'd1,
    KIND_MOUSE = 2'd2
  } kind_e;

  // Relative delta with acceleration: |d| > 3 becomes 2|d| - 3.
  function automatic logic signed [9:0] accel(input logic [BYTE_W-1:0] raw);
    logic signed [9:0] d;
    logic signed [9:0] a;
    d = 10'(signed'(raw));
    a = (d < 0) ? -d : d;
    if (a > 10'(ACCEL_KNEE)) begin
      a = a + a - 10'(ACCEL_KNEE);
    end
    return (d < 0) ? -a : a;
  endfunction

endpackage

### design/trc_if.sv
// Valid/ready channel interfaces for packet bytes in and cursor results out.
// Depends on trc_pkg for field widths.
interface trc_in_if;
  import trc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              end_of_packet;

  modport source (output valid, output rx_byte, output end_of_packet, input ready);
  modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

interface trc_out_if;
  import trc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OUT_COORD_W-1:0] cursor_x;
  logic [OUT_COORD_W-1:0] cursor_y;
  logic                   left_button;
  logic                   right_button;
  logic [1:0]             report_kind;

  modport source (output valid, output cursor_x, output cursor_y, output left_button,
                  output right_button, output report_kind, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input left_button,
                  input right_button, input report_kind, output ready);
endinterface

### design/touch_report_to_cursor_top.sv
// Packet bytes enter one per cycle unless a last byte held in stage 1 waits. Each
// byte reads the previous report at its position from both halves of a two-bank
// byte memory and writes itself into the staging bank from the stage-1 register;
// an accepted packet flips the bank select, so storing it costs no copy. The
// result of a packet passes the stage-1 register and then the result register. A
// touch report with the tip down goes through two three-stage scaling units;
// during that time bytes keep flowing but the next last byte waits. The report
// memory needs no clearing after reset, so the block takes items from the first cycle.
module touch_report_to_cursor_top import trc_pkg::*; #(
  parameter int unsigned MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF,
  parameter int unsigned COORD_BITS       = COORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  trc_in_if.sink            in_i,
  trc_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned AW    = $clog2(MAX_REPORT_BYTES);
  localparam int unsigned PW    = $clog2(MAX_REPORT_BYTES + 1);
  localparam int unsigned DIM_W = COORD_BITS + 1;
  localparam int unsigned SW    = COORD_BITS + 2;

  // ---------------- configuration ----------------
  logic [SCREEN_W-1:0] scr_w_q, scr_h_q;
  logic [MAXIN_W-1:0]  max_in_q;
  logic                cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q  <= SCREEN_WIDTH_RST;
      scr_h_q  <= SCREEN_HEIGHT_RST;
      max_in_q <= MAX_INPUT_RST;
    end else if (cfg_wr) begin
      case (paddr[APB_AW-1:2])
        REG_SCREEN_WIDTH:  scr_w_q  <= pwdata[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: scr_h_q  <= pwdata[SCREEN_W-1:0];
        REG_MAX_INPUT_LEN: max_in_q <= pwdata[MAXIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[APB_AW-1:2])
      REG_SCREEN_WIDTH:  prdata = 32'(scr_w_q);
      REG_SCREEN_HEIGHT: prdata = 32'(scr_h_q);
      REG_MAX_INPUT_LEN: prdata = 32'(max_in_q);
      default:           prdata = '0;
    endcase
  end

  // Effective screen size: 0 counts as 1, capped at 2^COORD_BITS.
  function automatic logic [DIM_W-1:0] dim_eff(input logic [SCREEN_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (32'(v) > (32'd1 << COORD_BITS)) begin
      return DIM_W'(32'd1 << COORD_BITS);
    end
    return DIM_W'(v);
  endfunction

  logic [DIM_W-1:0]      dim_w, dim_h;
  logic [COORD_BITS-1:0] w_m1, h_m1;
  logic [DECL_W-1:0]     size_lim;

  assign dim_w = dim_eff(scr_w_q);
  assign dim_h = dim_eff(scr_h_q);
  assign w_m1  = COORD_BITS'(dim_w - DIM_W'(1));
  assign h_m1  = COORD_BITS'(dim_h - DIM_W'(1));
  assign size_lim = (max_in_q < MAXIN_W'(MIN_INPUT_LEN) ||
                     DECL_W'(max_in_q) > DECL_W'(MAX_REPORT_BYTES)) ?
                    DECL_W'(MAX_REPORT_BYTES) : DECL_W'(max_in_q);

  // ---------------- byte entry and memory read ----------------
  logic          in_fire, s1_fire;
  logic [PW-1:0] pos_q;
  logic          pos_in;
  logic [AW-1:0] rd_addr;

  assign in_fire = in_i.valid && in_i.ready;
  assign pos_in  = pos_q < PW'(MAX_REPORT_BYTES);
  assign rd_addr = pos_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire) begin
      if (in_i.end_of_packet) begin
        pos_q <= '0;
      end else if (pos_in) begin
        pos_q <= pos_q + PW'(1);
      end
    end
  end

  // Bank bank_q holds the previous report, the other bank the staging copy.
  logic [BYTE_W-1:0] rep_mem [2 ** (AW + 1)];
  logic [BYTE_W-1:0] rd0_q, rd1_q;
  logic              bank_q;

  logic              s1_v_q, s1_eop_q, s1_in_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic [AW-1:0]     s1_addr_q;

  always_ff @(posedge clk_i) begin
    if (in_fire && pos_in) begin
      rd0_q <= rep_mem[{1'b0, rd_addr}];
      rd1_q <= rep_mem[{1'b1, rd_addr}];
    end
    if (s1_fire && s1_in_q) begin
      rep_mem[{~bank_q, s1_addr_q}] <= s1_byte_q;
    end
    if (in_fire) begin
      s1_byte_q <= in_i.rx_byte;
      s1_eop_q  <= in_i.end_of_packet;
      s1_in_q   <= pos_in;
      s1_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_fire) begin
      s1_v_q <= 1'b1;
    end else if (s1_fire) begin
      s1_v_q <= 1'b0;
    end
  end

  assign in_i.ready = !s1_v_q || s1_fire;

  // ---------------- packet state and decision ----------------
  logic [DECL_W-1:0] decl_q, decl_n;
  logic              same_q, same_n;
  logic [BYTE_W-1:0] fb_q [FIELD_BYTES];
  logic [BYTE_W-1:0] fb_n [FIELD_BYTES];
  logic [PW-1:0]     prev_len_q, cnt;
  logic [BYTE_W-1:0] prev_byte;
  logic              accept_pkt;

  always_comb begin
    decl_n = decl_q;
    if (s1_in_q && s1_addr_q == AW'(0)) begin
      decl_n = DECL_W'(s1_byte_q);
    end else if (s1_in_q && s1_addr_q == AW'(1)) begin
      decl_n = {s1_byte_q, decl_q[BYTE_W-1:0]};
    end
    for (int i = 0; i < FIELD_BYTES; i++) begin
      fb_n[i] = (s1_in_q && s1_addr_q == AW'(i + 2)) ? s1_byte_q : fb_q[i];
    end
    prev_byte = bank_q ? rd1_q : rd0_q;
    same_n = same_q && !(s1_in_q && PW'(s1_addr_q) < prev_len_q && prev_byte != s1_byte_q);
    cnt = s1_in_q ? PW'(s1_addr_q) + PW'(1) : PW'(MAX_REPORT_BYTES);
    accept_pkt = decl_n >= DECL_W'(MIN_DECL_LEN) && decl_n <= size_lim &&
                 decl_n <= DECL_W'(cnt) &&
                 !(decl_n == DECL_W'(prev_len_q) && same_n);
  end

  // ---------------- cursor update ----------------
  logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic                  busy_q, out_free, scale_start, scale_done;
  logic                  done_x, done_y;
  logic [COORD_BITS-1:0] sc_x, sc_y;
  logic                  is_touch, is_mouse, tip;
  logic [DECL_W-1:0]     x_raw, y_raw;
  logic [TOUCH_W-1:0]    x_c, y_c;
  logic signed [SW-1:0]  sum_x, sum_y;
  logic [COORD_BITS-1:0] nx, ny;
  logic                  n_left, n_right;
  kind_e                 n_kind;
  logic                  out_load;

  assign out_free = !out_o.valid || out_o.ready;
  assign s1_fire  = s1_v_q && (!s1_eop_q || (!busy_q && out_free));

  always_comb begin
    is_touch = accept_pkt && fb_n[0] == ID_TOUCH;
    is_mouse = accept_pkt && fb_n[0] == ID_MOUSE;
    tip      = fb_n[1][TIP_BIT];
    x_raw    = {fb_n[3], fb_n[2]};
    y_raw    = {fb_n[5], fb_n[4]};
    x_c = '0;
    y_c = '0;
    // Short touch with tip down scales from zero.
    if (decl_n >= DECL_W'(FULL_TOUCH_LEN)) begin
      x_c = (x_raw > DECL_W'(TOUCH_MAX_X)) ? TOUCH_W'(TOUCH_MAX_X) : x_raw[TOUCH_W-1:0];
      y_c = (y_raw > DECL_W'(TOUCH_MAX_Y)) ? TOUCH_W'(TOUCH_MAX_Y) : y_raw[TOUCH_W-1:0];
    end
    sum_x = $signed({2'b00, pos_x_q}) + SW'(accel(fb_n[2]));
    sum_y = $signed({2'b00, pos_y_q}) + SW'(accel(fb_n[3]));

    nx      = pos_x_q;
    ny      = pos_y_q;
    n_left  = 1'b0;
    n_right = 1'b0;
    n_kind  = KIND_NONE;
    if (is_touch) begin
      // Lift-off keeps the cursor, clamped to the screen.
      n_kind = KIND_TOUCH;
      nx = (pos_x_q > w_m1) ? w_m1 : pos_x_q;
      ny = (pos_y_q > h_m1) ? h_m1 : pos_y_q;
    end else if (is_mouse) begin
      n_kind  = KIND_MOUSE;
      n_left  = fb_n[1][LEFT_BIT];
      n_right = fb_n[1][RIGHT_BIT];
      if (sum_x < 0) begin
        nx = '0;
      end else if ($unsigned(sum_x) > SW'(w_m1)) begin
        nx = w_m1;
      end else begin
        nx = sum_x[COORD_BITS-1:0];
      end
      if (sum_y < 0) begin
        ny = '0;
      end else if ($unsigned(sum_y) > SW'(h_m1)) begin
        ny = h_m1;
      end else begin
        ny = sum_y[COORD_BITS-1:0];
      end
    end
  end

  assign scale_start = s1_fire && s1_eop_q && is_touch && tip;
  assign out_load    = s1_fire && s1_eop_q && !scale_start;
  assign scale_done  = done_x && done_y;

  trc_scale #(
    .COORD_BITS (COORD_BITS),
    .DIVISOR    (TOUCH_MAX_X)
  ) u_scale_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .coord_i (x_c),
    .dim_i   (dim_w),
    .done_o  (done_x),
    .q_o     (sc_x)
  );

  trc_scale #(
    .COORD_BITS (COORD_BITS),
    .DIVISOR    (TOUCH_MAX_Y)
  ) u_scale_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .coord_i (y_c),
    .dim_i   (dim_h),
    .done_o  (done_y),
    .q_o     (sc_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q     <= '0;
      same_q     <= 1'b1;
      fb_q       <= '{default: '0};
      prev_len_q <= '0;
      bank_q     <= 1'b0;
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      busy_q     <= 1'b0;
    end else begin
      if (s1_fire) begin
        if (s1_eop_q) begin
          decl_q <= '0;
          same_q <= 1'b1;
          fb_q   <= '{default: '0};
          if (accept_pkt) begin
            bank_q     <= ~bank_q;
            prev_len_q <= PW'(decl_n);
          end
        end else begin
          decl_q <= decl_n;
          same_q <= same_n;
          fb_q   <= fb_n;
        end
      end
      if (out_load) begin
        pos_x_q <= nx;
        pos_y_q <= ny;
      end else if (scale_done) begin
        pos_x_q <= sc_x;
        pos_y_q <= sc_y;
      end
      if (scale_start) begin
        busy_q <= 1'b1;
      end else if (scale_done) begin
        busy_q <= 1'b0;
      end
    end
  end

  // ---------------- result register ----------------
  logic                  out_v_q;
  logic [COORD_BITS-1:0] ox_q, oy_q;
  logic                  ol_q, or_q;
  kind_e                 ok_q;
  logic [COORD_BITS+OUT_COORD_W-1:0] ox_ext, oy_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load || scale_done) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ox_q <= nx;
      oy_q <= ny;
      ol_q <= n_left;
      or_q <= n_right;
      ok_q <= n_kind;
    end else if (scale_done) begin
      ox_q <= sc_x;
      oy_q <= sc_y;
      ol_q <= 1'b0;
      or_q <= 1'b0;
      ok_q <= KIND_TOUCH;
    end
  end

  assign ox_ext = {{OUT_COORD_W{1'b0}}, ox_q};
  assign oy_ext = {{OUT_COORD_W{1'b0}}, oy_q};

  assign out_o.valid        = out_v_q;
  assign out_o.cursor_x     = ox_ext[OUT_COORD_W-1:0];
  assign out_o.cursor_y     = oy_ext[OUT_COORD_W-1:0];
  assign out_o.left_button  = ol_q;
  assign out_o.right_button = or_q;
  assign out_o.report_kind  = ok_q;

endmodule

### design/trc_scale.sv
// Touch coordinate to screen scaling: coord * dim / DIVISOR, clamped to dim-1.
// Three register stages: product, reciprocal estimate, correction. Uses trc_pkg.
module trc_scale import trc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned DIVISOR    = TOUCH_MAX_X
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [TOUCH_W-1:0]    coord_i,
  input  logic [COORD_BITS:0]   dim_i,
  output logic                  done_o,
  output logic [COORD_BITS-1:0] q_o
);

  // coord <= DIVISOR < 2^TOUCH_W, dim <= 2^COORD_BITS, so product < 2^NW.
  localparam int unsigned NW = TOUCH_W + COORD_BITS;
  localparam int unsigned RW = NW - 11;
  localparam int unsigned QW = COORD_BITS + 1;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << NW) / 64'(DIVISOR));

  logic            a_v_q, b_v_q, done_q;
  logic [NW-1:0]   n_a_q, n_b_q;
  logic [QW-1:0]   dim_a_q, dim_b_q;
  logic [QW-1:0]   qe_b_q;
  logic [COORD_BITS-1:0] q_q;

  logic [NW+RW-1:0] prod;
  logic [NW:0]      back, rem;
  logic [QW-1:0]    q_fix;
  logic [COORD_BITS-1:0] q_d;

  // Estimate is q or q-1; one compare-subtract fixes it.
  assign prod = (NW+RW)'(n_a_q) * (NW+RW)'(RECIP);

  always_comb begin
    back  = (NW+1)'(qe_b_q) * (NW+1)'(DIVISOR);
    rem   = (NW+1)'(n_b_q) - back;
    q_fix = (rem >= (NW+1)'(DIVISOR)) ? qe_b_q + QW'(1) : qe_b_q;
    q_d   = (q_fix >= dim_b_q) ? COORD_BITS'(dim_b_q - QW'(1)) : COORD_BITS'(q_fix);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      a_v_q  <= start_i;
      b_v_q  <= a_v_q;
      done_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_a_q   <= NW'(coord_i) * NW'(dim_i);
      dim_a_q <= dim_i;
    end
    if (a_v_q) begin
      n_b_q   <= n_a_q;
      dim_b_q <= dim_a_q;
      qe_b_q  <= prod[NW +: QW];
    end
    if (b_v_q) begin
      q_q <= q_d;
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

### design/trc_checker.sv
// Port-level checks on the result channel of touch_report_to_cursor_top.
// Uses trc_pkg; attached to the top level by the bind at the end of the file.
module trc_checker import trc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [OUT_COORD_W-1:0] cursor_x_i,
  input logic [OUT_COORD_W-1:0] cursor_y_i,
  input logic                   left_button_i,
  input logic                   right_button_i,
  input logic [1:0]             report_kind_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(cursor_x_i) && $stable(cursor_y_i) &&
      $stable(left_button_i) && $stable(right_button_i) && $stable(report_kind_i))
    else $error("result payload changed while stalled");

  // Buttons only come from a relative report.
  a_buttons_mouse_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && report_kind_i != KIND_MOUSE |-> !left_button_i && !right_button_i)
    else $error("button set on a non-mouse result");

  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind touch_report_to_cursor_top trc_checker u_trc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .cursor_x_i     (out_o.cursor_x),
  .cursor_y_i     (out_o.cursor_y),
  .left_button_i  (out_o.left_button),
  .right_button_i (out_o.right_button),
  .report_kind_i  (out_o.report_kind)
);
